// ===== rtl/ctr_pkg.sv =====
// Package for the chunk transfer receiver: command, reply and phase codes,
// field widths and the bitmap request type. No dependencies.
`default_nettype none

package ctr_pkg;

    // field widths fixed by the word formats
    localparam int TOT_W  = 13;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int SEQ_W  = 32;
    localparam int IDLE_W = 8;
    localparam int OSEQ_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [IDLE_W-1:0] IDLE_MAX   = 8'd255;
    localparam logic [IDLE_W-1:0] IDLE_RESET = 8'd12;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_DATA  = 3'd1,
        CMD_FIN   = 3'd2,
        CMD_OTHER = 3'd3,
        CMD_TIMER = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REPLY_NONE     = 2'd0,
        REPLY_INIT_ACK = 2'd1,
        REPLY_DATA_ACK = 2'd2,
        REPLY_FIN_ACK  = 2'd3
    } reply_t;

    typedef enum logic [1:0] {
        PH_RECEIVING = 2'd0,
        PH_TIME_WAIT = 2'd1,
        PH_FINISHED  = 2'd2,
        PH_ABORTED   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_CHUNKS = 2'd0,
        CFG_CLIENT_IP    = 2'd1,
        CFG_CLIENT_PORT  = 2'd2,
        CFG_MAX_IDLE     = 2'd3
    } cfg_idx_t;

    // request from the control logic to the chunk bitmap
    typedef struct packed {
        logic rd_en;   // read the addressed entry, data next cycle
        logic wr_en;   // mark the addressed entry as seen
    } bm_req_t;

endpackage

`default_nettype wire

// ===== rtl/ctr_bitmap.sv =====
// Chunk-seen bitmap: single-port synchronous memory, one bit per chunk,
// with a clearing sweep after reset. Depends on ctr_pkg.
`default_nettype none

module ctr_bitmap #(
    parameter int DEPTH = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctr_pkg::bm_req_t  req,
    input  wire logic [ADDR_W-1:0] addr,
    output logic                   rd_bit,
    output logic                   busy
);

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_busy_reg;
    logic              rd_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // one port: sweep write, mark write or read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= 1'b0;
        else if (req.wr_en)
            mem[addr] <= 1'b1;
        else if (req.rd_en)
            rd_bit_reg <= mem[addr];
    end

    assign rd_bit = rd_bit_reg;
    assign busy   = clr_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/chunk_transfer_receiver.sv =====
// Top level of the chunk transfer receiver: stream ports, configuration
// registers, session control and output register. Depends on ctr_pkg and
// ctr_bitmap.
`default_nettype none

// Receive side of one chunked transfer session. Each input word is a decoded
// packet or a timer expiry and yields exactly one output word with the reply,
// the store request and the session phase after the word. The chunk bitmap
// is a single-port memory, read in the cycle a word is taken and written
// back when the word is processed, so no new word is taken until the last
// one is processed. The output register lets the next word be taken while
// a result waits. After reset the bitmap is swept clear, one entry a cycle,
// through all MAX_CHUNKS entries; no input word is taken during the sweep,
// while configuration writes are taken at all times.
module chunk_transfer_receiver #(
    parameter int MAX_CHUNKS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] source_ip, [47:32] source_port, [48] header_ok,
    // [80:49] sequence_number, [87:81] zero
    input  wire logic [87:0] s_axis_tdata,
    // [2:0] command
    input  wire logic [2:0]  s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] reply_kind, [13:2] reply_sequence, [14] store_chunk,
    // [26:15] chunk_index, [28:27] session_phase, [31:29] zero
    output logic [31:0]      m_axis_tdata,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [ctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ctr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int EFF_W = (CNT_W > ctr_pkg::TOT_W) ? CNT_W : ctr_pkg::TOT_W;

    // configuration registers
    logic [ctr_pkg::TOT_W-1:0]  total_reg;
    logic [ctr_pkg::IP_W-1:0]   client_ip_reg;
    logic [ctr_pkg::PORT_W-1:0] client_port_reg;
    logic [ctr_pkg::IDLE_W-1:0] max_idle_reg;

    // session state
    ctr_pkg::phase_t            phase_reg, phase_next;
    logic [ctr_pkg::IDLE_W-1:0] idle_reg, idle_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    // word held while its bitmap entry is read
    logic                       s1_valid_reg;
    logic [2:0]                 s1_cmd_reg;
    logic [ctr_pkg::IP_W-1:0]   s1_ip_reg;
    logic [ctr_pkg::PORT_W-1:0] s1_port_reg;
    logic                       s1_hdr_reg;
    logic [ctr_pkg::SEQ_W-1:0]  s1_seq_reg;

    // output register
    logic                        out_valid_reg;
    ctr_pkg::reply_t             out_kind_reg, kind_next;
    logic [ctr_pkg::OSEQ_W-1:0]  out_rseq_reg, rseq_next;
    logic                        out_store_reg, store_next;
    logic [ctr_pkg::OSEQ_W-1:0]  out_index_reg, index_next;
    ctr_pkg::phase_t             out_phase_reg;

    ctr_pkg::bm_req_t            bm_req;
    logic [IDX_W-1:0]            bm_addr;
    logic                        bm_rd_bit;
    logic                        bm_busy;

    logic                        accept;
    logic                        process;
    logic                        from_client;
    logic                        in_range;
    logic [EFF_W-1:0]            eff_total;
    logic [ctr_pkg::IDLE_W-1:0]  idle_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !s1_valid_reg && !bm_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign process       = s1_valid_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= '0;
            client_ip_reg   <= '0;
            client_port_reg <= '0;
            max_idle_reg    <= ctr_pkg::IDLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ctr_pkg::CFG_TOTAL_CHUNKS: total_reg       <= cfg_data[ctr_pkg::TOT_W-1:0];
                ctr_pkg::CFG_CLIENT_IP:    client_ip_reg   <= cfg_data[ctr_pkg::IP_W-1:0];
                ctr_pkg::CFG_CLIENT_PORT:  client_port_reg <= cfg_data[ctr_pkg::PORT_W-1:0];
                ctr_pkg::CFG_MAX_IDLE:     max_idle_reg    <= cfg_data[ctr_pkg::IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    // bitmap: read on accept, mark on a new in-range chunk
    assign bm_req.rd_en = accept;
    assign bm_req.wr_en = process && store_next;
    assign bm_addr      = accept ? s_axis_tdata[49 +: IDX_W] : s1_seq_reg[IDX_W-1:0];

    ctr_bitmap #(
        .DEPTH  (MAX_CHUNKS),
        .ADDR_W (IDX_W)
    ) u_bitmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (bm_req),
        .addr   (bm_addr),
        .rd_bit (bm_rd_bit),
        .busy   (bm_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (process)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= s_axis_tuser;
            s1_ip_reg   <= s_axis_tdata[31:0];
            s1_port_reg <= s_axis_tdata[47:32];
            s1_hdr_reg  <= s_axis_tdata[48];
            s1_seq_reg  <= s_axis_tdata[80:49];
        end
    end

    // chunk range is the smaller of the total and the bitmap depth
    assign eff_total = (EFF_W'(total_reg) < EFF_W'(MAX_CHUNKS))
                     ? EFF_W'(total_reg) : EFF_W'(MAX_CHUNKS);
    assign in_range    = s1_seq_reg < ctr_pkg::SEQ_W'(eff_total);
    assign from_client = (s1_ip_reg == client_ip_reg) && (s1_port_reg == client_port_reg);
    assign idle_inc    = (idle_reg == ctr_pkg::IDLE_MAX) ? idle_reg
                       : idle_reg + ctr_pkg::IDLE_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        idle_next  = idle_reg;
        count_next = count_reg;
        kind_next  = ctr_pkg::REPLY_NONE;
        rseq_next  = '0;
        store_next = 1'b0;
        index_next = '0;
        unique case (phase_reg)
            ctr_pkg::PH_RECEIVING:
            begin
                if (s1_cmd_reg == ctr_pkg::CMD_TIMER)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= max_idle_reg)
                        phase_next = ctr_pkg::PH_ABORTED;
                end
                else if (from_client)
                begin
                    idle_next = '0;
                    if (s1_hdr_reg)
                    begin
                        case (s1_cmd_reg)
                            ctr_pkg::CMD_INIT:
                                kind_next = ctr_pkg::REPLY_INIT_ACK;
                            ctr_pkg::CMD_DATA:
                            begin
                                if (in_range)
                                begin
                                    if (!bm_rd_bit)
                                    begin
                                        store_next = 1'b1;
                                        index_next = s1_seq_reg[ctr_pkg::OSEQ_W-1:0];
                                        count_next = count_reg + CNT_W'(1);
                                    end
                                    kind_next = ctr_pkg::REPLY_DATA_ACK;
                                    rseq_next = s1_seq_reg[ctr_pkg::OSEQ_W-1:0];
                                end
                            end
                            ctr_pkg::CMD_FIN:
                            begin
                                if (EFF_W'(count_reg) == eff_total)
                                begin
                                    kind_next  = ctr_pkg::REPLY_FIN_ACK;
                                    phase_next = ctr_pkg::PH_TIME_WAIT;
                                end
                            end
                            default: ;   // other packet types and undefined codes
                        endcase
                    end
                end
            end
            ctr_pkg::PH_TIME_WAIT:
            begin
                if (s1_cmd_reg == ctr_pkg::CMD_TIMER)
                    phase_next = ctr_pkg::PH_FINISHED;
                else if (from_client && s1_hdr_reg && s1_cmd_reg == ctr_pkg::CMD_FIN)
                    kind_next = ctr_pkg::REPLY_FIN_ACK;
            end
            default: ;   // finished or aborted: everything ignored
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ctr_pkg::PH_RECEIVING;
            idle_reg  <= '0;
            count_reg <= '0;
        end
        else if (process)
        begin
            phase_reg <= phase_next;
            idle_reg  <= idle_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_kind_reg  <= kind_next;
            out_rseq_reg  <= rseq_next;
            out_store_reg <= store_next;
            out_index_reg <= index_next;
            out_phase_reg <= phase_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_phase_reg, out_index_reg, out_store_reg,
                            out_rseq_reg, out_kind_reg};

endmodule

`default_nettype wire
